>>> hw/rtl/srl_pkg.sv
// ----------------------------------------------------------------------------
// srl_pkg: shared types and constants for the smallest-region lookup
// Table geometry, beat payloads and the stored entry layout.
// ----------------------------------------------------------------------------
package srl_pkg;

	// table geometry
	localparam int MOD_SLOTS = 32;
	localparam int SEG_SLOTS = 16;
	localparam int DEPTH     = MOD_SLOTS * SEG_SLOTS;
	localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MOD_W     = (MOD_SLOTS > 1) ? $clog2(MOD_SLOTS) : 1;
	localparam int SEG_W     = (SEG_SLOTS > 1) ? $clog2(SEG_SLOTS) : 1;

	// field widths
	localparam int ADDR_W  = 64;
	localparam int LABEL_W = 8;
	localparam int SLOT_W  = 5;
	localparam int SEGF_W  = 4;

	// beat modes
	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	typedef struct packed {
		logic                       mode;
		logic [SLOT_W-1:0]          module_slot;
		logic [SEGF_W-1:0]          segment_slot;
		logic                       entry_valid;
		logic [ADDR_W-1:0]          region_start_in;
		logic [ADDR_W-1:0]          region_end_in;
		logic signed [LABEL_W-1:0]  region_label_in;
		logic [ADDR_W-1:0]          lookup_address;
	} in_item_t;

	typedef struct packed {
		logic                       found;
		logic [SLOT_W-1:0]          hit_module;
		logic signed [LABEL_W-1:0]  hit_label;
		logic [ADDR_W-1:0]          hit_offset;
		logic [ADDR_W-1:0]          hit_start;
		logic [ADDR_W-1:0]          hit_end;
	} out_item_t;

	// one table row as held in RAM
	typedef struct packed {
		logic                 valid;
		logic [ADDR_W-1:0]    region_start;
		logic [ADDR_W-1:0]    region_end;
		logic [LABEL_W-1:0]   label;
	} entry_t;

endpackage

>>> hw/rtl/srl_in_if.sv
// ----------------------------------------------------------------------------
// srl_in_if: request channel
// Valid/ready channel carrying table writes and lookups.
// ----------------------------------------------------------------------------
interface srl_in_if;
	logic             valid;
	logic             ready;
	srl_pkg::in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/srl_out_if.sv
// ----------------------------------------------------------------------------
// srl_out_if: result channel
// Valid/ready channel carrying one lookup result per beat.
// ----------------------------------------------------------------------------
interface srl_out_if;
	logic               valid;
	logic               ready;
	srl_pkg::out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/srl_ram.sv
// ----------------------------------------------------------------------------
// srl_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module srl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/smallest_region_address_lookup.sv
// ----------------------------------------------------------------------------
// smallest_region_address_lookup: smallest containing region search
// Region table in RAM, scanned one row per cycle by a shared compare unit.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch beats carry either a table write (mode 0) or a lookup (mode 1).
//   A write gives no result; a slot outside the table is dropped. A lookup
//   gives exactly one beat on out_ch.
//   A lookup reads every table row through one RAM read port, one row per
//   cycle; in_ch is not ready from accept until the result is loaded, and
//   then takes the next beat.
//   Each row passes a two-stage compare unit: containment and size first,
//   then a strict less-than against the best size so far, so earlier rows
//   win ties and a size of all ones never matches.
//   After reset the block walks the table once clearing all valid marks,
//   during which in_ch is not ready.
//   The result sits in an output register; a new beat is taken while it
//   waits. If out_ch stalls when the next lookup finishes, the block holds
//   that result until the register frees.
// ----------------------------------------------------------------------------
module smallest_region_address_lookup (
	input logic        clk,
	input logic        arst_n,
	srl_in_if.sink     in_ch,
	srl_out_if.source  out_ch
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_WAIT  = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	localparam logic [srl_pkg::IDX_W-1:0] IDX_LAST = srl_pkg::IDX_W'(srl_pkg::DEPTH - 1);
	localparam logic [srl_pkg::SEG_W-1:0] SEG_LAST = srl_pkg::SEG_W'(srl_pkg::SEG_SLOTS - 1);

	logic [2:0]                     state_q;
	logic [srl_pkg::IDX_W-1:0]      idx_q;
	logic [srl_pkg::MOD_W-1:0]      mod_q;
	logic [srl_pkg::SEG_W-1:0]      seg_q;
	logic [srl_pkg::ADDR_W-1:0]     addr_q;

	// compare pipeline
	logic                           rd_s1;
	logic                           last_s1;
	logic [srl_pkg::MOD_W-1:0]      mod_s1;
	logic                           match_s2;
	logic                           last_s2;
	logic [srl_pkg::ADDR_W-1:0]     size_s2;
	logic [srl_pkg::ADDR_W-1:0]     st_s2;
	logic [srl_pkg::ADDR_W-1:0]     en_s2;
	logic [srl_pkg::LABEL_W-1:0]    lab_s2;
	logic [srl_pkg::MOD_W-1:0]      mod_s2;

	// best match so far
	logic                           hit_q;
	logic [srl_pkg::ADDR_W-1:0]     best_size_q;
	logic [srl_pkg::MOD_W-1:0]      best_mod_q;
	logic [srl_pkg::LABEL_W-1:0]    best_lab_q;
	logic [srl_pkg::ADDR_W-1:0]     best_st_q;
	logic [srl_pkg::ADDR_W-1:0]     best_en_q;

	logic                           out_valid_q;
	srl_pkg::out_item_t             out_q;

	// RAM ports
	logic                           ram_we;
	logic [srl_pkg::IDX_W-1:0]      ram_waddr;
	srl_pkg::entry_t                ram_wdata;
	logic [$bits(srl_pkg::entry_t)-1:0] ram_rdata;
	srl_pkg::entry_t                rd_ent;

	logic                           in_fire;
	logic                           wr_in_range;
	logic                           contains_s1;
	logic [srl_pkg::ADDR_W-1:0]     size_s1;
	logic                           take_s2;
	logic                           out_free;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;

	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = out_q;

	// write path: clearing pass or table load beat
	assign wr_in_range = (int'(in_ch.payload.module_slot) < srl_pkg::MOD_SLOTS) &&
	                     (int'(in_ch.payload.segment_slot) < srl_pkg::SEG_SLOTS);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '0;
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
		end else if (in_fire && in_ch.payload.mode == srl_pkg::MODE_WRITE && wr_in_range) begin
			ram_we    = 1'b1;
			ram_waddr = srl_pkg::IDX_W'(int'(in_ch.payload.module_slot) * srl_pkg::SEG_SLOTS +
			                            int'(in_ch.payload.segment_slot));
			ram_wdata.valid        = in_ch.payload.entry_valid;
			ram_wdata.region_start = in_ch.payload.region_start_in;
			ram_wdata.region_end   = in_ch.payload.region_end_in;
			ram_wdata.label        = in_ch.payload.region_label_in;
		end
	end

	srl_ram #(
		.WIDTH ($bits(srl_pkg::entry_t)),
		.DEPTH (srl_pkg::DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	// compare stage 1: containment and region size
	assign rd_ent      = srl_pkg::entry_t'(ram_rdata);
	assign contains_s1 = rd_s1 && rd_ent.valid &&
	                     (addr_q >= rd_ent.region_start) && (addr_q < rd_ent.region_end);
	assign size_s1     = rd_ent.region_end - rd_ent.region_start;

	// compare stage 2: strictly smaller wins
	assign take_s2 = match_s2 && (size_s2 < best_size_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			idx_q       <= '0;
			mod_q       <= '0;
			seg_q       <= '0;
			rd_s1       <= 1'b0;
			last_s1     <= 1'b0;
			match_s2    <= 1'b0;
			last_s2     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1    <= (state_q == ST_SCAN);
			last_s1  <= (state_q == ST_SCAN) && (idx_q == IDX_LAST);
			match_s2 <= contains_s1;
			last_s2  <= last_s1;
			// result valid: load on finish, drop once taken
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (idx_q == IDX_LAST) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_fire && in_ch.payload.mode == srl_pkg::MODE_LOOKUP) begin
						idx_q   <= '0;
						mod_q   <= '0;
						seg_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (seg_q == SEG_LAST) begin
						seg_q <= '0;
						mod_q <= mod_q + 1'b1;
					end else begin
						seg_q <= seg_q + 1'b1;
					end
					if (idx_q == IDX_LAST) begin
						idx_q   <= '0;
						state_q <= ST_WAIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_WAIT: begin
					if (last_s2) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		mod_s1  <= mod_q;
		size_s2 <= size_s1;
		st_s2   <= rd_ent.region_start;
		en_s2   <= rd_ent.region_end;
		lab_s2  <= rd_ent.label;
		mod_s2  <= mod_s1;

		if (state_q == ST_IDLE && in_fire) begin
			addr_q      <= in_ch.payload.lookup_address;
			hit_q       <= 1'b0;
			best_size_q <= '1;
			best_mod_q  <= '0;
			best_lab_q  <= '0;
			best_st_q   <= '0;
			best_en_q   <= '0;
		end else if (take_s2) begin
			hit_q       <= 1'b1;
			best_size_q <= size_s2;
			best_mod_q  <= mod_s2;
			best_lab_q  <= lab_s2;
			best_st_q   <= st_s2;
			best_en_q   <= en_s2;
		end

		// result register
		if (state_q == ST_FIN && out_free) begin
			out_q.found      <= hit_q;
			out_q.hit_module <= srl_pkg::SLOT_W'(best_mod_q);
			out_q.hit_label  <= best_lab_q;
			out_q.hit_offset <= hit_q ? (addr_q - best_st_q) : '0;
			out_q.hit_start  <= best_st_q;
			out_q.hit_end    <= best_en_q;
		end
	end

endmodule

>>> verif/smallest_region_address_lookup_test.sv
// ----------------------------------------------------------------------------
// smallest_region_address_lookup_test: self-checking bench for the region lookup
// Loads region entries and resolves addresses through the request channel and
// compares every result beat with a hand-made value or a behavioral copy of the
// region table. Hand-made beats cover bounds, ties, removal, empty and full-range
// regions; random traffic then builds overlapping and nested regions and probes
// addresses in, at and just outside them, with random idling on both channels.
// ----------------------------------------------------------------------------
module smallest_region_address_lookup_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 7;
	localparam int RANDOM_BEATS = 1080;
	localparam int BURST_BEATS  = 6;
	localparam int LONG_HOLD    = 2500;
	localparam int TAIL_CYCLES  = 600;
	localparam int CYCLE_LIMIT  = 3_000_000;

	localparam srl_pkg::out_item_t NO_HIT = '0;

	typedef struct {
		srl_pkg::in_item_t  beat;
		bit                 typed;
		srl_pkg::out_item_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	srl_in_if  in_ch();
	srl_out_if out_ch();

	smallest_region_address_lookup u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// behavioral copy of the region table
	logic [srl_pkg::ADDR_W-1:0]         region_lo   [srl_pkg::DEPTH];
	logic [srl_pkg::ADDR_W-1:0]         region_hi   [srl_pkg::DEPTH];
	logic signed [srl_pkg::LABEL_W-1:0] region_tag  [srl_pkg::DEPTH];
	bit                                 region_live [srl_pkg::DEPTH];

	srl_pkg::out_item_t pending_hits[$];
	int                 written[$];
	dir_row_t           dir_rows[$];

	int errors;
	int cycles;
	int n_writes;
	int n_lookups;
	int n_found;
	bit hold_off_req;
	bit send_calm;
	bit recv_calm;
	logic [srl_pkg::ADDR_W-1:0] win_base;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// smallest valid region holding addr; earlier row wins a tie
	function automatic srl_pkg::out_item_t smallest_hit(logic [srl_pkg::ADDR_W-1:0] addr);
		srl_pkg::out_item_t         r;
		logic [srl_pkg::ADDR_W-1:0] best;
		logic [srl_pkg::ADDR_W-1:0] size;
		r = NO_HIT;
		best = '1;
		for (int i = 0; i < srl_pkg::DEPTH; i++) begin
			if (region_live[i] && addr >= region_lo[i] && addr < region_hi[i]) begin
				size = region_hi[i] - region_lo[i];
				if (size < best) begin
					best = size;
					r.found = 1'b1;
					r.hit_module = srl_pkg::SLOT_W'(i / srl_pkg::SEG_SLOTS);
					r.hit_label = region_tag[i];
					r.hit_offset = addr - region_lo[i];
					r.hit_start = region_lo[i];
					r.hit_end = region_hi[i];
				end
			end
		end
		return r;
	endfunction

	// every field random; callers then shape the ones that matter
	function automatic srl_pkg::in_item_t noise_beat();
		srl_pkg::in_item_t b;
		b.mode = 1'($urandom);
		b.module_slot = srl_pkg::SLOT_W'($urandom);
		b.segment_slot = srl_pkg::SEGF_W'($urandom);
		b.entry_valid = 1'($urandom);
		b.region_start_in = rand64();
		b.region_end_in = rand64();
		b.region_label_in = srl_pkg::LABEL_W'($urandom);
		b.lookup_address = rand64();
		return b;
	endfunction

	function automatic srl_pkg::in_item_t wr_beat(int m, int s, bit v, logic [63:0] st,
			logic [63:0] en, logic signed [7:0] lab);
		srl_pkg::in_item_t b;
		b = noise_beat();
		b.mode = srl_pkg::MODE_WRITE;
		b.module_slot = srl_pkg::SLOT_W'(m);
		b.segment_slot = srl_pkg::SEGF_W'(s);
		b.entry_valid = v;
		b.region_start_in = st;
		b.region_end_in = en;
		b.region_label_in = lab;
		return b;
	endfunction

	function automatic srl_pkg::in_item_t lk_beat(logic [63:0] addr);
		srl_pkg::in_item_t b;
		b = noise_beat();
		b.mode = srl_pkg::MODE_LOOKUP;
		b.lookup_address = addr;
		return b;
	endfunction

	function automatic srl_pkg::out_item_t hit_res(int m, logic signed [7:0] lab,
			logic [63:0] off, logic [63:0] st, logic [63:0] en);
		srl_pkg::out_item_t r;
		r.found = 1'b1;
		r.hit_module = srl_pkg::SLOT_W'(m);
		r.hit_label = lab;
		r.hit_offset = off;
		r.hit_start = st;
		r.hit_end = en;
		return r;
	endfunction

	function automatic void add_row(srl_pkg::in_item_t b, bit typed, srl_pkg::out_item_t want);
		dir_row_t r;
		r.beat = b;
		r.typed = typed;
		r.want = want;
		dir_rows.push_back(r);
	endfunction

	// address near or inside a region written earlier, or anywhere at all
	function automatic logic [63:0] probe_address();
		int          k;
		logic [63:0] st;
		logic [63:0] en;
		logic [63:0] span;
		if (written.size() == 0 || $urandom_range(0, 4) == 0) begin
			case ($urandom_range(0, 3))
				0: return '0;
				1: return '1;
				2: return win_base + 64'($urandom_range(0, 'hFFFF));
				default: return rand64();
			endcase
		end
		k = written[$urandom_range(0, written.size() - 1)];
		st = region_lo[k];
		en = region_hi[k];
		span = en - st;
		case ($urandom_range(0, 5))
			0: return st;
			1: return en - 1;
			2: return en;
			3: return st - 1;
			default: return (en > st) ? st + rand64() % span : st;
		endcase
	endfunction

	// random region: window, nested, duplicate, wide, full-range, empty/reversed
	function automatic srl_pkg::in_item_t random_write();
		srl_pkg::in_item_t b;
		int                k;
		logic [63:0]       st;
		logic [63:0]       en;
		logic [63:0]       p_lo;
		logic [63:0]       p_hi;
		b = noise_beat();
		b.mode = srl_pkg::MODE_WRITE;
		b.entry_valid = ($urandom_range(0, 7) != 0);
		if ($urandom_range(0, 63) == 0)
			win_base = rand64();
		k = (written.size() == 0) ? 0 : written[$urandom_range(0, written.size() - 1)];
		p_lo = region_lo[k];
		p_hi = region_hi[k];
		case ($urandom_range(0, 9))
			4, 5: begin
				if (written.size() != 0 && p_hi > p_lo) begin
					st = p_lo + rand64() % (p_hi - p_lo);
					en = st + 1 + rand64() % (p_hi - st);
				end else begin
					st = win_base + 64'($urandom_range(0, 'hFFFF));
					en = st + 64'($urandom_range(1, 'h1000));
				end
			end
			6: begin
				st = (written.size() != 0) ? p_lo : win_base;
				en = (written.size() != 0) ? p_hi : win_base + 1;
			end
			7: begin
				st = rand64() >> $urandom_range(0, 8);
				en = st + (rand64() >> $urandom_range(0, 4));
			end
			8: begin
				case ($urandom_range(0, 2))
					0: begin st = '0; en = '1; end
					1: begin st = 64'd1; en = '1; end
					default: begin st = '0; en = 64'hFFFF_FFFF_FFFF_FFFE; end
				endcase
			end
			9: begin
				st = win_base + 64'($urandom_range(0, 'hFFFF));
				en = st - 64'($urandom_range(0, 16));
			end
			default: begin
				st = win_base + 64'($urandom_range(0, 'hFFFF));
				en = st + 1 + (rand64() >> $urandom_range(40, 63));
			end
		endcase
		b.region_start_in = st;
		b.region_end_in = en;
		return b;
	endfunction

	// offer one beat; on accept update the table copy or queue the expected result
	task automatic push_beat(srl_pkg::in_item_t b, bit typed, srl_pkg::out_item_t want);
		int                 gap;
		int                 idx;
		srl_pkg::out_item_t calc;
		if ($urandom_range(0, 31) == 0)
			send_calm = !send_calm;
		gap = send_calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.payload <= b;
		do @(posedge clk); while (!in_ch.ready);
		if (b.mode == srl_pkg::MODE_LOOKUP) begin
			calc = smallest_hit(b.lookup_address);
			pending_hits.push_back(typed ? want : calc);
			n_lookups++;
			if (calc.found)
				n_found++;
		end else if (int'(b.module_slot) < srl_pkg::MOD_SLOTS &&
				int'(b.segment_slot) < srl_pkg::SEG_SLOTS) begin
			idx = int'(b.module_slot) * srl_pkg::SEG_SLOTS + int'(b.segment_slot);
			region_lo[idx] = b.region_start_in;
			region_hi[idx] = b.region_end_in;
			region_tag[idx] = b.region_label_in;
			region_live[idx] = b.entry_valid;
			written.push_back(idx);
			n_writes++;
		end
	endtask

	task automatic cmp_field(string fname, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
			errors++;
		end
	endtask

	task automatic check_result(srl_pkg::out_item_t got);
		srl_pkg::out_item_t want;
		if (pending_hits.size() == 0) begin
			$display("%0t: result beat with none expected, expected nothing, got %h",
				$time, got);
			errors++;
			return;
		end
		want = pending_hits.pop_front();
		cmp_field("found", 64'(want.found), 64'(got.found));
		cmp_field("hit_module", 64'(want.hit_module), 64'(got.hit_module));
		cmp_field("hit_label", {56'd0, want.hit_label}, {56'd0, got.hit_label});
		cmp_field("hit_offset", want.hit_offset, got.hit_offset);
		cmp_field("hit_start", want.hit_start, got.hit_start);
		cmp_field("hit_end", want.hit_end, got.hit_end);
	endtask

	// hand-made beats: bounds, ties, removal, empty, reversed and full-range regions
	function automatic void build_directed();
		add_row(lk_beat('0), 1'b1, NO_HIT);
		add_row(lk_beat('1), 1'b1, NO_HIT);
		add_row(wr_beat(0, 0, 1'b1, 64'h1000, 64'h2000, 8'sd5), 1'b0, NO_HIT);
		add_row(lk_beat(64'h1000), 1'b1, hit_res(0, 8'sd5, 64'h0, 64'h1000, 64'h2000));
		add_row(lk_beat(64'h1FFF), 1'b1, hit_res(0, 8'sd5, 64'hFFF, 64'h1000, 64'h2000));
		add_row(lk_beat(64'h2000), 1'b1, NO_HIT);
		add_row(wr_beat(31, 15, 1'b1, 64'h1800, 64'h1900, -8'sd1), 1'b0, NO_HIT);
		add_row(lk_beat(64'h1880), 1'b1, hit_res(31, -8'sd1, 64'h80, 64'h1800, 64'h1900));
		// same size as the bss region but earlier in scan order
		add_row(wr_beat(3, 7, 1'b1, 64'h1800, 64'h1900, 8'sd126), 1'b0, NO_HIT);
		add_row(lk_beat(64'h1800), 1'b1, hit_res(3, 8'sd126, 64'h0, 64'h1800, 64'h1900));
		// removal keeps contents but drops the entry from lookups
		add_row(wr_beat(3, 7, 1'b0, 64'h1800, 64'h1900, 8'sd126), 1'b0, NO_HIT);
		add_row(lk_beat(64'h18FF), 1'b1, hit_res(31, -8'sd1, 64'hFF, 64'h1800, 64'h1900));
		// full-range region never matches
		add_row(wr_beat(5, 0, 1'b1, 64'h0, '1, 8'sd1), 1'b0, NO_HIT);
		add_row(lk_beat(64'hFFFF_FFFF_FFFF_0000), 1'b1, NO_HIT);
		// empty and reversed regions
		add_row(wr_beat(5, 1, 1'b1, 64'h5000, 64'h5000, 8'sd2), 1'b0, NO_HIT);
		add_row(wr_beat(5, 2, 1'b1, 64'h6000, 64'h5000, 8'sd3), 1'b0, NO_HIT);
		add_row(lk_beat(64'h5000), 1'b1, NO_HIT);
		add_row(lk_beat(64'h5800), 1'b1, NO_HIT);
		// one short of full range does match
		add_row(wr_beat(6, 0, 1'b1, 64'h1, '1, 8'sh7E), 1'b0, NO_HIT);
		add_row(lk_beat(64'hFFFF_FFFF_FFFF_FFFE), 1'b1,
			hit_res(6, 8'sh7E, 64'hFFFF_FFFF_FFFF_FFFD, 64'h1, '1));
		add_row(wr_beat(16, 8, 1'b1, 64'hFFFF_FFFF_FFFF_FF00, '1, -8'sd128), 1'b0, NO_HIT);
		add_row(lk_beat(64'hFFFF_FFFF_FFFF_FFFE), 1'b0, NO_HIT);
		add_row(lk_beat(64'h1000), 1'b0, NO_HIT);
		add_row(wr_beat(10, 10, 1'b1, 64'h1000, 64'h2000, 8'sd127), 1'b0, NO_HIT);
		add_row(lk_beat(64'h1234), 1'b0, NO_HIT);
	endfunction

	// run watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("smallest_region_address_lookup_test NOT OK");
			$finish;
		end
	end

	// result side: random stalls, one long hold-off on request, check each beat
	initial begin : result_sink
		int                 stall;
		srl_pkg::out_item_t got;
		out_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				stall = LONG_HOLD;
				hold_off_req = 1'b0;
			end else begin
				if ($urandom_range(0, 31) == 0)
					recv_calm = !recv_calm;
				stall = recv_calm ? 0 : $urandom_range(0, 7);
			end
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			got = out_ch.payload;
			check_result(got);
		end
	end

	// request side
	initial begin : request_source
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.payload <= '0;
		win_base = rand64();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		build_directed();
		foreach (dir_rows[i])
			push_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_hits.size() != 0);

		// lookups pile up behind a stalled result channel
		hold_off_req = 1'b1;
		repeat (BURST_BEATS)
			push_beat(lk_beat(probe_address()), 1'b0, NO_HIT);

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			if (i == RANDOM_BEATS / 2) begin
				// quiet point: let every result drain before going on
				in_ch.valid <= 1'b0;
				do @(posedge clk); while (pending_hits.size() != 0);
			end
			if ($urandom_range(0, 99) < 45)
				push_beat(lk_beat(probe_address()), 1'b0, NO_HIT);
			else
				push_beat(random_write(), 1'b0, NO_HIT);
		end
		in_ch.valid <= 1'b0;

		do @(posedge clk); while (pending_hits.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d table writes and %0d lookups (%0d found, %0d missed)",
			n_writes, n_lookups, n_found, n_lookups - n_found);
		$display("with random idling on both channels and one long result stall");
		if (errors == 0)
			$display("smallest_region_address_lookup_test OK");
		else
			$display("smallest_region_address_lookup_test NOT OK");
		$finish;
	end

endmodule
